>>> src/sound_cpu_interrupt_latch_macros.svh
// assertion macros shared by the interrupt latch modules
`ifndef SOUND_CPU_INTERRUPT_LATCH_MACROS_SVH
`define SOUND_CPU_INTERRUPT_LATCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCIL_CHECK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// next-cycle implication, checked outside reset
`define SCIL_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);

`endif

>>> src/scil_pkg.sv
// types and constants of the sound cpu interrupt latch
package scil_pkg;

    // access modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register selects
    localparam logic [2:0] SEL_ENABLE  = 3'd0;
    localparam logic [2:0] SEL_PENDING = 3'd1;
    localparam logic [2:0] SEL_CLEAR   = 3'd2;
    localparam logic [2:0] SEL_LMAP0   = 3'd3;
    localparam logic [2:0] SEL_LMAP1   = 3'd4;
    localparam logic [2:0] SEL_LMAP2   = 3'd5;
    localparam logic [2:0] SEL_LEVEL   = 3'd6;
    localparam logic [2:0] SEL_ACCEPT  = 3'd7;

    // bit fields
    localparam logic [15:0] PEND_FIELD = 16'h07FF;
    localparam logic [15:0] SCPU_BIT   = 16'h0020;
    localparam logic [15:0] TICK_BIT   = 16'h0400;
    localparam logic [2:0]  TOP_LEVEL_BIT = 3'd7;

    localparam int NUM_LMAPS = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  reg_sel;
        logic [15:0] write_data;
        logic [15:0] write_mask;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        fiq_line;
    } t_out_item;

endpackage

>>> src/scil_core.sv
// interrupt state registers, register access decode and level evaluation
module scil_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  scil_pkg::t_in_item i_item,
    output scil_pkg::t_out_item o_result
);

    `include "sound_cpu_interrupt_latch_macros.svh"

    logic [15:0] r_en,  n_en;
    logic [15:0] r_pend, n_pend;
    logic [7:0]  r_lmap [scil_pkg::NUM_LMAPS];
    logic [7:0]  n_lmap [scil_pkg::NUM_LMAPS];
    logic        r_req, n_req;
    logic [2:0]  r_lvl, n_lvl;
    logic        r_fiq, n_fiq;

    logic [15:0] dm;
    logic        do_eval;
    logic [15:0] act;
    logic [2:0]  pos;
    logic [2:0]  lvl;
    logic [15:0] rd;
    logic        lmap_wr;
    logic [1:0]  lmap_idx;

    assign dm       = i_item.write_data & i_item.write_mask;
    assign lmap_wr  = (i_item.mode == scil_pkg::MODE_WRITE) &&
                      (i_item.reg_sel inside {scil_pkg::SEL_LMAP0, scil_pkg::SEL_LMAP1,
                                              scil_pkg::SEL_LMAP2});
    assign lmap_idx = 2'(i_item.reg_sel - scil_pkg::SEL_LMAP0);

    // register access: masked updates and read mux
    always_comb begin
        n_en    = r_en;
        n_pend  = r_pend;
        n_req   = r_req;
        n_lvl   = r_lvl;
        n_fiq   = r_fiq;
        do_eval = 1'b0;
        rd      = '0;
        for (int k = 0; k < scil_pkg::NUM_LMAPS; k++) begin
            n_lmap[k] = r_lmap[k];
        end
        case (i_item.mode)
            scil_pkg::MODE_READ: begin
                case (i_item.reg_sel)
                    scil_pkg::SEL_ENABLE:  rd = r_en;
                    scil_pkg::SEL_PENDING: rd = r_pend;
                    scil_pkg::SEL_LEVEL: begin
                        rd    = {13'd0, r_lvl};
                        n_fiq = 1'b0;
                    end
                    default: rd = '0;
                endcase
            end
            scil_pkg::MODE_WRITE: begin
                case (i_item.reg_sel)
                    scil_pkg::SEL_ENABLE: begin
                        n_en    = (r_en & ~i_item.write_mask) | dm;
                        do_eval = 1'b1;
                    end
                    scil_pkg::SEL_PENDING: begin
                        if ((dm & scil_pkg::SCPU_BIT) != '0) begin
                            n_pend = r_pend | scil_pkg::SCPU_BIT;
                        end
                        do_eval = 1'b1;
                    end
                    scil_pkg::SEL_CLEAR: begin
                        n_pend  = r_pend & ~dm;
                        do_eval = 1'b1;
                    end
                    scil_pkg::SEL_LMAP0, scil_pkg::SEL_LMAP1, scil_pkg::SEL_LMAP2: begin
                        do_eval = 1'b1;
                    end
                    scil_pkg::SEL_ACCEPT: begin
                        if (dm[0]) begin
                            n_req   = 1'b0;
                            do_eval = 1'b1;
                        end
                    end
                    default: do_eval = 1'b0;
                endcase
                if (lmap_wr) begin
                    n_lmap[lmap_idx] = (r_lmap[lmap_idx] & ~i_item.write_mask[7:0]) |
                                       dm[7:0];
                end
            end
            scil_pkg::MODE_TICK: begin
                n_pend  = r_pend | scil_pkg::TICK_BIT;
                do_eval = 1'b1;
            end
            default: rd = '0;
        endcase

        // lowest enabled pending bit, clamped to the top level bit
        act = n_en & n_pend & scil_pkg::PEND_FIELD;
        pos = scil_pkg::TOP_LEVEL_BIT;
        for (int i = 6; i >= 0; i--) begin
            if (act[i]) begin
                pos = 3'(i);
            end
        end
        for (int k = 0; k < scil_pkg::NUM_LMAPS; k++) begin
            lvl[k] = n_lmap[k][pos];
        end

        // on an evaluating item with enabled pending bits, latch a nonzero level when no request is outstanding
        if (do_eval && (act != '0) && !n_req && (lvl != '0)) begin
            n_req = 1'b1;
            n_lvl = lvl;
            n_fiq = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= '0;
            r_pend <= '0;
            r_req  <= 1'b0;
            r_lvl  <= '0;
            r_fiq  <= 1'b0;
            for (int k = 0; k < scil_pkg::NUM_LMAPS; k++) begin
                r_lmap[k] <= '0;
            end
        end else if (i_fire) begin
            r_en   <= n_en;
            r_pend <= n_pend;
            r_req  <= n_req;
            r_lvl  <= n_lvl;
            r_fiq  <= n_fiq;
            for (int k = 0; k < scil_pkg::NUM_LMAPS; k++) begin
                r_lmap[k] <= n_lmap[k];
            end
        end
    end

    assign o_result.read_data = rd;
    assign o_result.fiq_line  = n_fiq;

    // checks
    `SCIL_CHECK(a_req_rise_fiq, $rose(r_req) |-> r_fiq, "request raised without fiq")
    `SCIL_CHECK(a_fiq_rise_lvl, $rose(r_fiq) |-> (r_lvl != 3'd0) && r_req, "fiq raised without level")
    `SCIL_CHECK_NEXT(a_idle_hold, !i_fire, $stable(r_pend) && $stable(r_en), "state moved without item")

endmodule

>>> src/sound_cpu_interrupt_latch.sv
// top level of the sound cpu interrupt latch: input stage, core and result register
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (scil_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (scil_pkg::t_out_item)
//
// one item per cycle while the output is not stalled; an item passes the input stage, then the result register
// the core evaluates an item combinationally between input stage and result register
// reset is synchronous, active low, and clears all interrupt state
// a stalled result holds the result register; the input stage still takes one more item
module sound_cpu_interrupt_latch (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  scil_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output scil_pkg::t_out_item o_out_item
);

    `include "sound_cpu_interrupt_latch_macros.svh"

    logic                r_in_valid;
    scil_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    scil_pkg::t_out_item r_out_item;
    scil_pkg::t_out_item core_result;
    logic                advance;
    logic                in_take;

    // stage moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    scil_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    `SCIL_CHECK(a_stall_has_item, o_in_stall |-> r_in_valid, "stall without a held item")
    `SCIL_CHECK_NEXT(a_blocked_holds, r_in_valid && r_out_valid && i_out_stall, r_in_valid && $stable(r_in_item), "held item lost")
    `SCIL_CHECK_NEXT(a_advance_fills, advance, r_out_valid, "result not registered")

endmodule
